// File: hdl/far_pkg.sv
`default_nettype none
package far_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int NUM_WIDTH = 2 * OPERAND_WIDTH + 1;
   localparam int DEN_WIDTH = 2 * OPERAND_WIDTH;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_WIDTH = 1;
   localparam int SHIFT_WIDTH = $clog2(NUM_WIDTH + 1);

   typedef struct packed {
      logic [OPERAND_WIDTH-1:0] left_num;
      logic [OPERAND_WIDTH-1:0] left_den;
      logic [OPERAND_WIDTH-1:0] right_num;
      logic [OPERAND_WIDTH-1:0] right_den;
   } req_type;

   typedef struct packed {
      logic [NUM_WIDTH-1:0] sum_num;
      logic [DEN_WIDTH-1:0] sum_den;
      logic                 is_empty;
   } rsp_type;

   // Job handed from the front to the back.
   typedef struct packed {
      logic [NUM_WIDTH-1:0] num;
      logic [DEN_WIDTH-1:0] den;
      logic                 is_empty;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_TWOS,
      BK_ODDU,
      BK_LOOP,
      BK_SCALE,
      BK_DIVN,
      BK_DIVD,
      BK_DONE
   } back_state_type;

endpackage
`default_nettype wire

// File: hdl/far_front.sv
`default_nettype none
module far_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire far_pkg::req_type  req_word,
   output logic                   job_valid,
   input  wire logic              job_ready,
   output far_pkg::job_type       job_word
);
   import far_pkg::*;

   front_state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [DEN_WIDTH-1:0] prod_ff, prod_in;
   logic [NUM_WIDTH-1:0] num_ff, num_in;
   logic empty_ff, empty_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      req_ff <= req_in;
      prod_ff <= prod_in;
      num_ff <= num_in;
      empty_ff <= empty_in;
   end

   // Form one cross product first, then the other cross product and the
   // denominator together on two multipliers.
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      prod_in = prod_ff;
      num_in = num_ff;
      empty_in = empty_ff;
      req_ready = 1'b0;
      job_valid = 1'b0;
      job_word.num = num_ff;
      job_word.den = prod_ff;
      job_word.is_empty = empty_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_word;
               empty_in = (req_word.left_num == '0) || (req_word.left_den == '0) ||
                          (req_word.right_num == '0) || (req_word.right_den == '0);
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            prod_in = req_ff.left_num * req_ff.right_den;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            num_in = {1'b0, prod_ff} + NUM_WIDTH'(req_ff.left_den * req_ff.right_num);
            prod_in = req_ff.left_den * req_ff.right_den;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            job_valid = 1'b1;
            if (job_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: hdl/far_queue.sv
`default_nettype none
module far_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire far_pkg::job_type  in_word,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output far_pkg::job_type       out_word
);
   import far_pkg::*;

   job_type mem_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_WIDTH-1:0] wr_ff, rd_ff;
   logic [QUEUE_IDX_WIDTH:0] count_ff;
   logic push, pop;

   assign in_ready = (count_ff != (QUEUE_IDX_WIDTH + 1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_word = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + {{QUEUE_IDX_WIDTH{1'b0}}, push}
                              - {{QUEUE_IDX_WIDTH{1'b0}}, pop};
      end
      if (push) mem_ff[wr_ff] <= in_word;
   end
endmodule
`default_nettype wire

// File: hdl/far_back.sv
`default_nettype none
module far_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   output logic                   job_ready,
   input  wire far_pkg::job_type  job_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output far_pkg::rsp_type       rsp_word
);
   import far_pkg::*;

   localparam int QW = NUM_WIDTH;

   back_state_type state_ff, state_in;
   logic [NUM_WIDTH-1:0] num_ff, num_in;
   logic [DEN_WIDTH-1:0] den_ff, den_in;
   logic [NUM_WIDTH-1:0] u_ff, u_in, v_ff, v_in;
   logic [SHIFT_WIDTH-1:0] twos_ff, twos_in;
   logic empty_ff, empty_in;
   // Restoring divider state.
   logic [NUM_WIDTH-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [SHIFT_WIDTH-1:0] cnt_ff, cnt_in;
   rsp_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;
   logic [NUM_WIDTH:0] trial;
   logic [NUM_WIDTH-1:0] dividend;
   logic [NUM_WIDTH-1:0] vdiff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      u_ff <= u_in;
      v_ff <= v_in;
      twos_ff <= twos_in;
      empty_ff <= empty_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word = out_ff;
   assign dividend = (state_ff == BK_DIVN) ? num_ff : {1'b0, den_ff};
   assign trial = {rem_ff, dividend[cnt_ff[SHIFT_WIDTH-1:0]]};
   assign vdiff = (u_ff > v_ff) ? (u_ff - v_ff) : (v_ff - u_ff);

   always_comb begin
      state_in = state_ff;
      num_in = num_ff;
      den_in = den_ff;
      u_in = u_ff;
      v_in = v_ff;
      twos_in = twos_ff;
      empty_in = empty_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      job_ready = 1'b0;
      if (rsp_ready) out_valid_in = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               num_in = job_word.num;
               den_in = job_word.den;
               u_in = job_word.num;
               v_in = {1'b0, job_word.den};
               twos_in = '0;
               empty_in = job_word.is_empty;
               state_in = job_word.is_empty ? BK_DONE : BK_TWOS;
            end
         end
         BK_TWOS: begin
            // strip common factors of two
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               twos_in = twos_ff + 1'b1;
            end else state_in = BK_ODDU;
         end
         BK_ODDU: begin
            if (!u_ff[0]) u_in = u_ff >> 1;
            else state_in = BK_LOOP;
         end
         BK_LOOP: begin
            // u stays odd; v halved while even, else replaced by |u-v|
            if (v_ff == '0) state_in = BK_SCALE;
            else if (!v_ff[0]) v_in = v_ff >> 1;
            else begin
               if (u_ff > v_ff) u_in = v_ff;
               v_in = vdiff;
            end
         end
         BK_SCALE: begin
            u_in = u_ff << twos_ff;
            rem_in = '0;
            quo_in = '0;
            cnt_in = SHIFT_WIDTH'(QW - 1);
            state_in = BK_DIVN;
         end
         BK_DIVN, BK_DIVD: begin
            if (trial >= {1'b0, u_ff}) begin
               rem_in = NUM_WIDTH'(trial - {1'b0, u_ff});
               quo_in = {quo_ff[NUM_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = trial[NUM_WIDTH-1:0];
               quo_in = {quo_ff[NUM_WIDTH-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               if (state_ff == BK_DIVN) begin
                  num_in = quo_in;
                  rem_in = '0;
                  quo_in = '0;
                  cnt_in = SHIFT_WIDTH'(QW - 1);
                  state_in = BK_DIVD;
               end else begin
                  den_in = quo_in[DEN_WIDTH-1:0];
                  state_in = BK_DONE;
               end
            end else cnt_in = cnt_ff - 1'b1;
         end
         BK_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_in.sum_num = empty_ff ? '0 : num_ff;
               out_in.sum_den = empty_ff ? '0 : den_ff;
               out_in.is_empty = empty_ff;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: hdl/fraction_add_reduce.sv
`default_nettype none
// Adds two unsigned fractions per word and returns the sum in lowest terms:
// numerator a*d+b*c, denominator b*d, both divided by their GCD. If any
// input field is zero the result is 0/0 with is_empty set. A front unit
// forms the products on two 16x16 multipliers and pushes a job into a
// two-entry queue; the back unit runs a binary GCD (one subtract or shift
// per cycle) and then two bit-serial restoring divisions, of the numerator
// and then of the denominator. The time a word takes is set by the GCD loop
// and the divider; an empty word skips both. The result sits in an output
// register, so the back unit may finish the next job meanwhile.
module fraction_add_reduce (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire far_pkg::req_type  req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output far_pkg::rsp_type       rsp_word
);
   import far_pkg::*;

   job_type f_job, b_job;
   logic f_valid, f_ready, b_valid, b_ready;

   // front: capture and multiply
   far_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .job_valid(f_valid), .job_ready(f_ready), .job_word(f_job)
   );

   // hold jobs between the two halves
   far_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_word(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_word(b_job)
   );

   // back: reduce and deliver
   far_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(b_valid), .job_ready(b_ready), .job_word(b_job),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );
endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
`default_nettype none

class sum_ledger;
   far_pkg::rsp_type pending[$];
   int mismatches = 0;

   // Reduce a/b + c/d to lowest terms with a Euclid GCD.
   function far_pkg::rsp_type reduce_sum(far_pkg::req_type w);
      far_pkg::rsp_type r;
      longint unsigned n, d, g, h, t;
      r = '0;
      if (w.left_num == 0 || w.left_den == 0 || w.right_num == 0 || w.right_den == 0) begin
         r.is_empty = 1'b1;
         return r;
      end
      n = longint'(w.left_num) * w.right_den + longint'(w.left_den) * w.right_num;
      d = longint'(w.left_den) * w.right_den;
      g = n;
      h = d;
      while (h != 0) begin
         t = g % h;
         g = h;
         h = t;
      end
      n = n / g;
      d = d / g;
      r.sum_num = n[$bits(r.sum_num)-1:0];
      r.sum_den = d[$bits(r.sum_den)-1:0];
      return r;
   endfunction

   function void note_word(far_pkg::req_type w);
      pending.push_back(reduce_sum(w));
   endfunction

   function void check_word(far_pkg::rsp_type got);
      far_pkg::rsp_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result word %h", got);
         return;
      end
      want = pending.pop_front();
      if (got.sum_num !== want.sum_num || got.sum_den !== want.sum_den
          || got.is_empty !== want.is_empty) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d e=%0b, got %0d/%0d e=%0b",
                     want.sum_num, want.sum_den, want.is_empty,
                     got.sum_num, got.sum_den, got.is_empty);
      end
   endfunction
endclass

module testbench;
   import far_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;

   sum_ledger ledger = new();
   int send_idle_pct = 0;   // chance the sender idles on a cycle
   int recv_stall_pct = 0;  // chance the receiver stalls on a cycle
   longint cycles = 0;

   fraction_add_reduce uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   always #5 clock = ~clock;

   // Watchdog: report a failure and stop if the run goes on too long.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Check each accepted result word; randomize ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_word(rsp_word);
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // Present one word and hold it until accepted; valid stays high on return
   // and is dropped by the next call's idle cycles or by drain().
   task automatic send_word(req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      ledger.note_word(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_field();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'd1;
         3: return 16'($urandom_range(15));
         4: return 16'h8000 | 16'($urandom);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_word();
      req_type w;
      w.left_num = pick_field();
      w.left_den = pick_field();
      w.right_num = pick_field();
      w.right_den = pick_field();
      // Keep most words non-empty so the GCD path gets exercised.
      if ($urandom_range(9) != 0) begin
         if (w.left_num == 0) w.left_num = 16'd1;
         if (w.left_den == 0) w.left_den = 16'hFFFF;
         if (w.right_num == 0) w.right_num = 16'd3;
         if (w.right_den == 0) w.right_den = 16'd2;
      end
      // Share a factor now and then so reduction really divides.
      if ($urandom_range(3) == 0) w.right_den = w.left_den;
      return w;
   endfunction

   int phase;

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, each empty operand, cancelling and equal sums.
      send_word('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_word('{16'd1, 16'd1, 16'd1, 16'd1});
      send_word('{16'hFFFF, 16'd1, 16'hFFFF, 16'd1});
      send_word('{16'd1, 16'hFFFF, 16'd1, 16'hFFFE});
      send_word('{16'd0, 16'd5, 16'd3, 16'd7});
      send_word('{16'd2, 16'd0, 16'd3, 16'd7});
      send_word('{16'd2, 16'd5, 16'd0, 16'd7});
      send_word('{16'd2, 16'd5, 16'd3, 16'd0});
      send_word('{16'd0, 16'd0, 16'd0, 16'd0});
      send_word('{16'd1, 16'd2, 16'd1, 16'd2});
      send_word('{16'd1, 16'd6, 16'd1, 16'd3});
      send_word('{16'h8000, 16'h8000, 16'h4000, 16'h4000});
      send_word('{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555});
      send_word('{16'd12345, 16'd65521, 16'd54321, 16'd65519});
      // Hold off until every expected word has come back.
      drain();

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            3: begin send_idle_pct = 30; recv_stall_pct = 30; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         repeat (307) send_word(random_word());
      end
      drain();
      repeat (400) @(posedge clock);

      if (ledger.mismatches == 0 && ledger.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

`default_nettype wire
